>>> rtl/core/shc_pkg.sv
// Package for the signature packet header checker.
// Holds the reject codes, the verdict struct and the field constants.
// No dependencies.
`timescale 1ns / 1ps

package shc_pkg;

  // Reject codes carried in the verdict
  typedef enum logic [3:0] {
    RSN_NONE     = 4'd0,
    RSN_TAG      = 4'd1,
    RSN_INDET    = 4'd2,
    RSN_VERSION  = 4'd3,
    RSN_HASHLEN  = 4'd4,
    RSN_TYPE     = 4'd5,
    RSN_ALGO     = 4'd6,
    RSN_HASH     = 4'd7,
    RSN_MPI_LONG = 4'd8
  } reason_t;

  // Verdict for one signature block
  typedef struct packed {
    logic [13:0] mpi_bytes;
    logic [2:0]  trailer_offset;
    logic        hash_select;
    reason_t     reject_reason;
    logic        accepted;
  } verdict_t;

  localparam int unsigned VerdictW = $bits(verdict_t);
  localparam int unsigned OutDataW = ((VerdictW + 7) / 8) * 8;

  // Tag byte fields
  localparam logic [7:0] TagAlways   = 8'h80;
  localparam logic [7:0] TagNewFmt   = 8'h40;
  localparam logic [7:0] TagTypeMask = 8'h3C;
  localparam logic [7:0] TagTypeSig  = 8'h08;
  localparam logic [7:0] TagLenMask  = 8'h03;

  // Length type codes of an old-format tag
  localparam logic [1:0] LenType1 = 2'd0;
  localparam logic [1:0] LenType2 = 2'd1;
  localparam logic [1:0] LenType4 = 2'd2;

  // Expected field values
  localparam logic [7:0] ExpVersion = 8'h03;
  localparam logic [7:0] ExpHashLen = 8'h05;
  localparam logic [7:0] ExpSigType = 8'h00;
  localparam logic [7:0] ExpPkAlgo  = 8'h01;
  localparam logic [7:0] HashSha1   = 8'h02;
  localparam logic [7:0] HashSha256 = 8'h08;

  // Offsets past the header
  localparam logic [4:0] OffVersion = 5'd0;
  localparam logic [4:0] OffHashLen = 5'd1;
  localparam logic [4:0] OffSigType = 5'd2;
  localparam logic [4:0] OffPkAlgo  = 5'd15;
  localparam logic [4:0] OffHashAlg = 5'd16;
  localparam logic [4:0] OffMpiHigh = 5'd19;
  localparam logic [4:0] OffMpiLow  = 5'd20;

  // Fixed bytes between header and MPI data
  localparam logic [16:0] FixedBytes = 17'd21;
  localparam logic [15:0] BlockSizeReset = 16'd2048;

  // Register index of block_size
  localparam logic RegBlockSize = 1'b0;

endpackage

>>> rtl/core/signature_packet_header_checker.sv
// Top level of the signature packet header checker.
// Depends on shc_pkg, shc_cfg, shc_parser and shc_out_reg.
`timescale 1ns / 1ps

// Checks an old-format version 3 signature packet header byte by byte.
// One byte request is taken every clock cycle; a byte passes the input
// register and the check logic, and its verdict (if any) is then held in the
// output register. One verdict per block; bytes after it are ignored until
// the next byte with s_tuser set. The input stalls only while a byte sits
// in the input register behind a verdict that waits in the output register
// with m_tready low. Write block_size only while no block bytes are in
// flight.

module signature_packet_header_checker (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sig_byte
  input  logic        s_tuser,   // start_req
  // verdicts
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [shc_pkg::OutDataW-1:0] m_tdata  // [0] accepted, [4:1] reject_reason,
                                                // [5] hash_select,
                                                // [8:6] trailer_offset,
                                                // [22:9] mpi_bytes
);

  logic              [15:0] block_size;
  logic              out_free;
  logic              res_valid;
  shc_pkg::verdict_t res;

  shc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .block_size (block_size)
  );

  shc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_start   (s_tuser),
    .block_size (block_size),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  shc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .din      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/core/shc_cfg.sv
// APB register file of the header checker: holds block_size.
// Depends on shc_pkg.
`timescale 1ns / 1ps

module shc_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] block_size
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == shc_pkg::RegBlockSize);
  assign wr_en   = psel & penable & pwrite & pready;

  // block_size register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= shc_pkg::BlockSizeReset;
    end else if (wr_en && reg_sel) begin
      block_size <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (reg_sel) begin
      prdata = {16'd0, block_size};
    end
  end

endmodule

>>> rtl/core/shc_parser.sv
// Input register, parse state and per-byte header checks.
// Depends on shc_pkg.
`timescale 1ns / 1ps

module shc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_start,
  input  logic [15:0]        block_size,
  input  logic               out_free,
  output logic               res_valid,
  output shc_pkg::verdict_t  res
);

  // input register
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_start;

  // parse state
  logic [4:0] pos;
  logic [2:0] hdr_len;
  logic       given;
  logic [7:0] mpi_high;
  logic       hash_kind;

  logic [4:0] pos_next;
  logic [2:0] hdr_len_next;
  logic       given_next;
  logic [7:0] mpi_high_next;
  logic       hash_kind_next;

  // view of state after an optional start mark
  logic [4:0] e_pos;
  logic [2:0] e_hdr;
  logic       e_given;
  logic [7:0] e_high;
  logic       e_hash;

  logic             take;
  logic             verdict;
  shc_pkg::reason_t reason;
  logic [13:0]      mpi;
  logic [4:0]       rel;
  logic [15:0]      bits;
  logic [16:0]      bits_rnd;
  logic [16:0]      need;

  assign take     = ir_valid & out_free;
  assign in_ready = ~ir_valid | out_free;

  // capture one byte request
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte  <= in_byte;
      ir_start <= in_start;
    end
  end

  assign e_pos   = ir_start ? 5'd0 : pos;
  assign e_hdr   = ir_start ? 3'd0 : hdr_len;
  assign e_given = ir_start ? 1'b0 : given;
  assign e_high  = ir_start ? 8'd0 : mpi_high;
  assign e_hash  = ir_start ? 1'b0 : hash_kind;

  assign rel      = e_pos - {2'd0, e_hdr};
  assign bits     = {e_high, ir_byte};
  assign bits_rnd = {1'b0, bits} + 17'd7;
  assign mpi      = bits_rnd[16:3];
  assign need     = {3'd0, mpi} + {14'd0, e_hdr} + shc_pkg::FixedBytes;

  // checks and next state
  always_comb begin
    pos_next       = e_pos;
    hdr_len_next   = e_hdr;
    given_next     = e_given;
    mpi_high_next  = e_high;
    hash_kind_next = e_hash;
    verdict        = 1'b0;
    reason         = shc_pkg::RSN_NONE;
    if (!e_given) begin
      pos_next = e_pos + 5'd1;
      if (e_pos == 5'd0) begin
        if (((ir_byte & shc_pkg::TagAlways) == 8'd0) ||
            ((ir_byte & shc_pkg::TagNewFmt) != 8'd0) ||
            ((ir_byte & shc_pkg::TagTypeMask) != shc_pkg::TagTypeSig)) begin
          verdict = 1'b1;
          reason  = shc_pkg::RSN_TAG;
        end else begin
          case (ir_byte[1:0])
            shc_pkg::LenType1: hdr_len_next = 3'd2;
            shc_pkg::LenType2: hdr_len_next = 3'd3;
            shc_pkg::LenType4: hdr_len_next = 3'd5;
            default: begin
              verdict = 1'b1;
              reason  = shc_pkg::RSN_INDET;
            end
          endcase
        end
      end else if (e_pos >= {2'd0, e_hdr}) begin
        case (rel)
          shc_pkg::OffVersion: if (ir_byte != shc_pkg::ExpVersion) begin
            verdict = 1'b1;
            reason  = shc_pkg::RSN_VERSION;
          end
          shc_pkg::OffHashLen: if (ir_byte != shc_pkg::ExpHashLen) begin
            verdict = 1'b1;
            reason  = shc_pkg::RSN_HASHLEN;
          end
          shc_pkg::OffSigType: if (ir_byte != shc_pkg::ExpSigType) begin
            verdict = 1'b1;
            reason  = shc_pkg::RSN_TYPE;
          end
          shc_pkg::OffPkAlgo: if (ir_byte != shc_pkg::ExpPkAlgo) begin
            verdict = 1'b1;
            reason  = shc_pkg::RSN_ALGO;
          end
          shc_pkg::OffHashAlg: begin
            if (ir_byte == shc_pkg::HashSha1) begin
              hash_kind_next = 1'b0;
            end else if (ir_byte == shc_pkg::HashSha256) begin
              hash_kind_next = 1'b1;
            end else begin
              verdict = 1'b1;
              reason  = shc_pkg::RSN_HASH;
            end
          end
          shc_pkg::OffMpiHigh: mpi_high_next = ir_byte;
          shc_pkg::OffMpiLow: begin
            verdict = 1'b1;
            reason  = (need > {1'b0, block_size}) ? shc_pkg::RSN_MPI_LONG
                                                 : shc_pkg::RSN_NONE;
          end
          default: ;
        endcase
      end
      if (verdict) begin
        given_next = 1'b1;
      end
    end
  end

  // verdict fields
  always_comb begin
    res.accepted       = (reason == shc_pkg::RSN_NONE);
    res.reject_reason  = reason;
    res.hash_select    = (reason == shc_pkg::RSN_NONE) ? hash_kind_next : 1'b0;
    res.trailer_offset = (hdr_len_next != 3'd0) ? (hdr_len_next + 3'd2) : 3'd0;
    res.mpi_bytes      = ((reason == shc_pkg::RSN_NONE) ||
                          (reason == shc_pkg::RSN_MPI_LONG)) ? mpi : 14'd0;
  end

  assign res_valid = take & verdict;

  // parse state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 5'd0;
      hdr_len   <= 3'd0;
      given     <= 1'b1;
      mpi_high  <= 8'd0;
      hash_kind <= 1'b0;
    end else if (take) begin
      pos       <= pos_next;
      hdr_len   <= hdr_len_next;
      given     <= given_next;
      mpi_high  <= mpi_high_next;
      hash_kind <= hash_kind_next;
    end
  end

  // a verdict closes the block
  a_verdict_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> given)
    else $error("verdict given but block still open");

  // a tag-level reject never reports a trailer offset
  a_tag_no_trailer: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.reject_reason == shc_pkg::RSN_TAG ||
                   res.reject_reason == shc_pkg::RSN_INDET))
      |-> (res.trailer_offset == 3'd0))
    else $error("trailer offset set on tag reject");

  // no verdict while the block is idle and no start mark comes
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (given && !ir_start) |-> !res_valid)
    else $error("verdict while idle");

endmodule

>>> rtl/core/shc_out_reg.sv
// Output register of the header checker: holds one verdict until taken.
// Depends on shc_pkg.
`timescale 1ns / 1ps

module shc_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  shc_pkg::verdict_t            din,
  output logic                         out_free,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [shc_pkg::OutDataW-1:0] m_tdata
);

  shc_pkg::verdict_t held;

  assign out_free = ~m_tvalid | m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push && out_free) begin
      held <= din;
    end
  end

  assign m_tdata = {{(shc_pkg::OutDataW - shc_pkg::VerdictW){1'b0}}, held};

  // accepted and reason always agree on delivered verdicts
  a_acc_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (held.accepted == (held.reject_reason == shc_pkg::RSN_NONE)))
    else $error("accepted flag disagrees with reason");

  // an accepted verdict carries a trailer offset past the header
  a_acc_trailer: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && held.accepted) |-> (held.trailer_offset >= 3'd4))
    else $error("accepted verdict with bad trailer offset");

  // a stalled verdict is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(held)))
    else $error("pending verdict lost");

endmodule
